FILE: rtl/core/onewire_scratchpad_checker_unit_assert.svh
// assertion macros used by the checker file owcc_checker.sv
// no dependencies; expects clk and rst_n in the including scope
`ifndef ONEWIRE_SCRATCHPAD_CHECKER_UNIT_ASSERT_SVH
`define ONEWIRE_SCRATCHPAD_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define OWCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owcc assertion failed");

// next-cycle implication, quiet during reset
`define OWCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owcc assertion failed");

`endif

FILE: rtl/core/owcc_pkg.sv
// shared types, constants and the crc-8 step for the scratchpad checker
// no dependencies
package owcc_pkg;

    localparam int FRAME_BYTES = 9;
    localparam logic [3:0] LAST_INDEX = 4'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [63:0] ALL_ONES_ID = 64'hFFFF_FFFF_FFFF_FFFF;
    // 512 degrees in 1/16 degree units
    localparam logic signed [15:0] FAULT_TEMPERATURE = 16'sd8192;

    localparam int IN_W = 8;
    localparam int OUT_W = 96;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [1:0] REG_SENSOR_KIND = 2'd0;
    localparam logic [1:0] REG_ERROR_LIMIT = 2'd1;
    localparam logic [1:0] REG_ABSENT_HOLD = 2'd2;

    localparam logic KIND_TEMPERATURE = 1'b0;

    typedef struct packed {
        logic        crc_ok;
        logic [63:0] bytes;
    } frame_t;

    typedef struct packed {
        logic        sensor_kind;
        logic [7:0]  error_limit;
        logic [15:0] absent_hold;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // reflected crc-8, one byte, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc;
        d = data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ d[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/owcc_regs.sv
// configuration registers behind the apb-style port
// depends on owcc_pkg
module owcc_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [owcc_pkg::DATA_W-1:0]   pwdata,
    output logic [owcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output owcc_pkg::cfg_t                cfg
);

    owcc_pkg::cfg_t cfg_reg;
    owcc_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                owcc_pkg::REG_SENSOR_KIND: cfg_next.sensor_kind = pwdata[0];
                owcc_pkg::REG_ERROR_LIMIT: cfg_next.error_limit = pwdata[7:0];
                owcc_pkg::REG_ABSENT_HOLD: cfg_next.absent_hold = pwdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_kind <= 1'b0;
            cfg_reg.error_limit <= 8'd3;
            cfg_reg.absent_hold <= 16'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            owcc_pkg::REG_SENSOR_KIND: prdata = {31'd0, cfg_reg.sensor_kind};
            owcc_pkg::REG_ERROR_LIMIT: prdata = {24'd0, cfg_reg.error_limit};
            owcc_pkg::REG_ABSENT_HOLD: prdata = {16'd0, cfg_reg.absent_hold};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/owcc_front.sv
// front end: takes bytes, tracks position, runs the crc and collects the id
// depends on owcc_pkg
module owcc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    input  logic                          frame_start,
    input  owcc_pkg::fifo_status_t        fifo_status,
    output logic                          push,
    output owcc_pkg::frame_t              push_frame
);

    logic [3:0]  byte_index_reg;
    logic [3:0]  byte_index_next;
    logic [7:0]  crc_acc_reg;
    logic [7:0]  crc_acc_next;
    logic [63:0] frame_bytes_reg;
    logic [63:0] frame_bytes_next;

    logic [3:0]  idx_eff;
    logic [7:0]  crc_eff;
    logic [63:0] bytes_eff;
    logic        accept;
    logic        is_crc_byte;

    assign in_ready = !fifo_status.full;
    assign accept   = in_valid & in_ready;

    // frame start clears the running state before the byte is used
    assign idx_eff   = frame_start ? 4'd0 : byte_index_reg;
    assign crc_eff   = frame_start ? 8'd0 : crc_acc_reg;
    assign bytes_eff = frame_start ? 64'd0 : frame_bytes_reg;

    assign is_crc_byte = (idx_eff >= owcc_pkg::LAST_INDEX);

    always_comb
    begin
        byte_index_next  = byte_index_reg;
        crc_acc_next     = crc_acc_reg;
        frame_bytes_next = frame_bytes_reg;
        if (accept)
        begin
            if (!is_crc_byte)
            begin
                byte_index_next  = idx_eff + 4'd1;
                crc_acc_next     = owcc_pkg::crc8_byte(crc_eff, rx_byte);
                frame_bytes_next = {bytes_eff[55:0], rx_byte};
            end
            else
            begin
                byte_index_next  = 4'd0;
                crc_acc_next     = 8'd0;
                frame_bytes_next = 64'd0;
            end
        end
    end

    assign push              = accept & is_crc_byte;
    assign push_frame.crc_ok = (crc_eff == rx_byte);
    assign push_frame.bytes  = bytes_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= 4'd0;
            crc_acc_reg     <= 8'd0;
            frame_bytes_reg <= 64'd0;
        end
        else
        begin
            byte_index_reg  <= byte_index_next;
            crc_acc_reg     <= crc_acc_next;
            frame_bytes_reg <= frame_bytes_next;
        end
    end

endmodule

FILE: rtl/core/owcc_fifo.sv
// short queue of finished frames between front and back
// depends on owcc_pkg
module owcc_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  owcc_pkg::frame_t         push_frame,
    input  logic                     pop,
    output owcc_pkg::frame_t         head,
    output owcc_pkg::fifo_status_t   status
);

    owcc_pkg::frame_t                entry_reg [owcc_pkg::FIFO_DEPTH];
    logic [owcc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [owcc_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
    logic [owcc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [owcc_pkg::FIFO_PTR_W-1:0] rd_ptr_next;
    logic [owcc_pkg::FIFO_CNT_W-1:0] count_reg;
    logic [owcc_pkg::FIFO_CNT_W-1:0] count_next;

    assign status.full  = (count_reg == owcc_pkg::FIFO_CNT_W'(owcc_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/owcc_back.sv
// back end: per-frame decision (temperature or key) and the output register
// depends on owcc_pkg
module owcc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  owcc_pkg::cfg_t                cfg,
    input  owcc_pkg::frame_t              head,
    input  owcc_pkg::fifo_status_t        fifo_status,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [owcc_pkg::OUT_W-1:0]    out_data
);

    logic [7:0]                    fail_count_reg;
    logic [7:0]                    fail_count_next;
    logic [15:0]                   absent_count_reg;
    logic [15:0]                   absent_count_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [owcc_pkg::OUT_W-1:0]    data_reg;

    logic signed [15:0]            temperature;
    logic                          temperature_updated;
    logic [63:0]                   key_id;
    logic                          key_updated;
    logic [owcc_pkg::OUT_W-1:0]    packed_word;

    assign pop = !fifo_status.empty && (!valid_reg || out_ready);

    always_comb
    begin
        temperature         = '0;
        temperature_updated = 1'b0;
        key_id              = 64'd0;
        key_updated         = 1'b0;
        fail_count_next     = fail_count_reg;
        absent_count_next   = absent_count_reg;
        if (cfg.sensor_kind == owcc_pkg::KIND_TEMPERATURE)
        begin
            if (head.crc_ok)
            begin
                // byte 1 is the high half, byte 0 (oldest, top of word) the low half
                temperature         = {head.bytes[55:48], head.bytes[63:56]};
                temperature_updated = 1'b1;
                fail_count_next     = 8'd0;
            end
            else if (fail_count_reg < cfg.error_limit)
            begin
                fail_count_next = fail_count_reg + 8'd1;
            end
            else
            begin
                temperature         = owcc_pkg::FAULT_TEMPERATURE;
                temperature_updated = 1'b1;
            end
        end
        else
        begin
            if (head.bytes == owcc_pkg::ALL_ONES_ID && absent_count_reg != 16'd0)
            begin
                absent_count_next = absent_count_reg - 16'd1;
            end
            else
            begin
                key_id      = head.bytes;
                key_updated = 1'b1;
                if (head.bytes == owcc_pkg::ALL_ONES_ID)
                    absent_count_next = cfg.absent_hold;
            end
        end
    end

    // word layout from bit 0: crc_ok, temperature, temperature_updated,
    // key_id, key_updated, error_count, zero pad
    assign packed_word = {5'd0, fail_count_next, key_updated, key_id,
                          temperature_updated, temperature, head.crc_ok};

    assign valid_next = pop ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count_reg   <= 8'd0;
            absent_count_reg <= 16'd0;
            valid_reg        <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                fail_count_reg   <= fail_count_next;
                absent_count_reg <= absent_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= packed_word;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/onewire_scratchpad_checker_unit.sv
// top level of the one-wire scratchpad checker
// depends on owcc_pkg, owcc_regs, owcc_front, owcc_fifo, owcc_back
//
// Takes one byte per cycle of a nine-byte one-wire scratchpad read and returns one word per
// frame. The finished frame enters the queue at the edge that takes the ninth byte; the
// result word is then loaded from the queue head into the output register once that register
// is empty or its word is being taken, and m_tvalid rises with it.
// Throughput is one byte per cycle while s_tready is high, set by
// the byte-wide crc-8 update in the front end; a two-entry frame queue sits between the front
// end and the decision stage, so incoming bytes keep flowing while a result word waits on
// m_tready, and s_tready drops only when both queue entries are held. A byte with tuser set
// starts a new frame; otherwise bytes are counted in sequence. Registers (sensor_kind at 0x0,
// error_limit at 0x4, absent_hold at 0x8) should be written only while no frame is in flight.
module onewire_scratchpad_checker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [owcc_pkg::IN_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                          s_tuser,   // [0] frame_start
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] crc_ok, [16:1] temperature, [17] temperature_updated, [81:18] key_id,
    // [82] key_updated, [90:83] error_count, [95:91] zero
    output logic [owcc_pkg::OUT_W-1:0]    m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owcc_pkg::ADDR_W-1:0]   paddr,
    input  logic [owcc_pkg::DATA_W-1:0]   pwdata,
    output logic [owcc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    owcc_pkg::cfg_t          cfg;
    owcc_pkg::fifo_status_t  fifo_status;
    owcc_pkg::frame_t        push_frame;
    owcc_pkg::frame_t        head;
    logic                    push;
    logic                    pop;

    owcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .fifo_status (fifo_status),
        .push        (push),
        .push_frame  (push_frame)
    );

    owcc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head       (head),
        .status     (fifo_status)
    );

    owcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head),
        .fifo_status (fifo_status),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata)
    );

endmodule

FILE: rtl/core/owcc_checker.sv
// port-level checks on the scratchpad checker, attached by bind
// depends on owcc_pkg and onewire_scratchpad_checker_unit_assert.svh
`include "onewire_scratchpad_checker_unit_assert.svh"

module owcc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [owcc_pkg::OUT_W-1:0]    m_tdata
);

    // a stalled result word stays put
    `OWCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a word never carries both a temperature and a key
    `OWCC_ASSERT_NOW(a_one_kind, m_tvalid, !(m_tdata[17] && m_tdata[82]))

    // no new temperature means the field reads zero
    `OWCC_ASSERT_NOW(a_temp_quiet, m_tvalid && !m_tdata[17], m_tdata[16:1] == 16'd0)

    // a good-crc reading always comes with the failure count cleared
    `OWCC_ASSERT_NOW(a_ok_clears, m_tvalid && m_tdata[0] && m_tdata[17], m_tdata[90:83] == 8'd0)

endmodule

bind onewire_scratchpad_checker_unit owcc_checker u_owcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_onewire_scratchpad_checker_unit.sv
// testbench for onewire_scratchpad_checker_unit: streams nine-byte scratchpad reads in
// several register settings and idle patterns and checks every result word against a
// behavioral predictor; depends on owcc_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_onewire_scratchpad_checker_unit;

    localparam logic KIND_KEY = 1'b1;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } bus_byte_t;

    typedef struct packed {
        logic        crc_ok;
        logic [15:0] temperature;
        logic        temp_new;
        logic [63:0] key_id;
        logic        key_new;
        logic [7:0]  err_cnt;
    } scratch_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [owcc_pkg::IN_W-1:0]     s_tdata;   // [7:0] rx_byte
    logic                          s_tuser;   // [0] frame_start
    logic                          m_tvalid;
    logic                          m_tready;
    // [0] crc_ok, [16:1] temperature, [17] temperature_updated, [81:18] key_id,
    // [82] key_updated, [90:83] error_count
    logic [owcc_pkg::OUT_W-1:0]    m_tdata;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [owcc_pkg::ADDR_W-1:0]   paddr;
    logic [owcc_pkg::DATA_W-1:0]   pwdata;
    logic [owcc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    onewire_scratchpad_checker_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    bus_byte_t       byte_q[$];
    scratch_result_t expected_q[$];

    int  idle_pct;
    int  stall_pct;
    int  bytes_queued;
    int  bytes_taken;
    int  results_checked;
    int  fault_reports;
    int  absent_reports;
    int  crc_fail_results;
    int  mismatches;
    int  quiet_cycles;
    logic byte_taken;

    // predictor state and its copy of the registers
    logic [3:0]  frame_pos;
    logic [7:0]  crc_run;
    logic [63:0] id_shift;
    logic [7:0]  fail_run;
    logic [15:0] absent_left;
    logic        cfg_kind;
    logic [7:0]  cfg_limit;
    logic [15:0] cfg_hold;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
            c = c[0] ? ((c >> 1) ^ owcc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic start);
        scratch_result_t r;
        if (start)
        begin
            frame_pos = '0;
            crc_run = '0;
            id_shift = '0;
        end
        if (frame_pos < owcc_pkg::LAST_INDEX)
        begin
            crc_run = crc8_next(crc_run, b);
            id_shift = {id_shift[55:0], b};
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            r = '0;
            r.crc_ok = (crc_run == b);
            if (cfg_kind == owcc_pkg::KIND_TEMPERATURE)
            begin
                if (r.crc_ok)
                begin
                    // byte 0 is the low half of the reading
                    r.temperature = {id_shift[55:48], id_shift[63:56]};
                    r.temp_new = 1'b1;
                    fail_run = '0;
                end
                else if (fail_run < cfg_limit)
                    fail_run = fail_run + 8'd1;
                else
                begin
                    r.temperature = owcc_pkg::FAULT_TEMPERATURE;
                    r.temp_new = 1'b1;
                end
            end
            else if (id_shift == owcc_pkg::ALL_ONES_ID && absent_left != 16'd0)
                absent_left = absent_left - 16'd1;
            else
            begin
                r.key_id = id_shift;
                r.key_new = 1'b1;
                if (id_shift == owcc_pkg::ALL_ONES_ID)
                    absent_left = cfg_hold;
            end
            r.err_cnt = fail_run;
            frame_pos = '0;
            crc_run = '0;
            id_shift = '0;
            expected_q.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            flag_mismatch(what, want, got);
    endtask

    // sender side: new byte at the falling edge once the previous one was taken, and a random m_tready
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
            if (s_tvalid && !byte_taken)
                ;
            else if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                {s_tuser, s_tdata} <= byte_q.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        byte_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            bytes_taken++;
            predict_byte(s_tdata, s_tuser);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        scratch_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
                flag_mismatch("unexpected result word", 64'd0, m_tdata[63:0]);
            else
            begin
                want = expected_q.pop_front();
                results_checked++;
                if (!want.crc_ok)
                    crc_fail_results++;
                if (want.temp_new && want.temperature == owcc_pkg::FAULT_TEMPERATURE
                    && !want.crc_ok)
                    fault_reports++;
                if (want.key_new && want.key_id == owcc_pkg::ALL_ONES_ID)
                    absent_reports++;
                check_field("crc_ok", want.crc_ok, m_tdata[0]);
                check_field("temperature", want.temperature, m_tdata[16:1]);
                check_field("temperature_updated", want.temp_new, m_tdata[17]);
                check_field("key_id", want.key_id, m_tdata[81:18]);
                check_field("key_updated", want.key_new, m_tdata[82]);
                check_field("error_count", want.err_cnt, m_tdata[90:83]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no word moved for %0d cycles, %0d results still due",
                     quiet_cycles, expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic start);
        byte_q.push_back({start, b});
        bytes_queued++;
    endtask

    // id holds byte 0 in its top bits
    task automatic queue_frame(input logic [63:0] id, input bit good_crc, input bit with_start);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            c = crc8_next(c, id[63-8*i -: 8]);
            queue_byte(id[63-8*i -: 8], with_start && i == 0);
        end
        if (!good_crc)
            c = c ^ 8'($urandom_range(1, 255));
        queue_byte(c, 1'b0);
    endtask

    task automatic queue_random(input int n);
        logic [7:0]  corner_bytes [4];
        logic [63:0] id;
        int          stop_at;
        int          kind_pick;
        int          len;
        corner_bytes = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        stop_at = bytes_queued + n;
        while (bytes_queued < stop_at)
        begin
            kind_pick = $urandom_range(99);
            if (kind_pick < 10)
            begin
                // noise with scattered frame starts
                len = $urandom_range(1, 12);
                repeat (len)
                    queue_byte(8'($urandom), $urandom_range(3) == 0);
            end
            else if (kind_pick < 20)
            begin
                // read cut short, the next frame normally restarts it
                len = $urandom_range(1, 8);
                queue_byte(8'($urandom), 1'b1);
                repeat (len - 1)
                    queue_byte(8'($urandom), 1'b0);
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2: id = owcc_pkg::ALL_ONES_ID;
                    3:       id = {corner_bytes[$urandom_range(3)],
                                   corner_bytes[$urandom_range(3)], 48'($urandom)};
                    default: id = {$urandom, $urandom};
                endcase
                queue_frame(id, $urandom_range(99) < 65, $urandom_range(9) != 0);
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            owcc_pkg::REG_SENSOR_KIND: mask = 32'h1;
            owcc_pkg::REG_ERROR_LIMIT: mask = 32'hFF;
            default:                   mask = 32'hFFFF;
        endcase
        case (idx)
            owcc_pkg::REG_SENSOR_KIND: cfg_kind = val[0];
            owcc_pkg::REG_ERROR_LIMIT: cfg_limit = val[7:0];
            default:                   cfg_hold = val[15:0];
        endcase
        // read back through the same port
        @(negedge clk);
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        check_field("register readback", val & mask, got);
    endtask

    task automatic new_setting(input logic kind, input logic [7:0] limit, input logic [15:0] hold,
                               input int idle, input int stall);
        wait_idle();
        reg_write(owcc_pkg::REG_SENSOR_KIND, {31'd0, kind});
        reg_write(owcc_pkg::REG_ERROR_LIMIT, {24'd0, limit});
        reg_write(owcc_pkg::REG_ABSENT_HOLD, {16'd0, hold});
        idle_pct = idle;
        stall_pct = stall;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_pct = 0;
        stall_pct = 0;
        bytes_queued = 0;
        bytes_taken = 0;
        results_checked = 0;
        fault_reports = 0;
        absent_reports = 0;
        crc_fail_results = 0;
        mismatches = 0;
        quiet_cycles = 0;
        byte_taken = 1'b0;
        frame_pos = '0;
        crc_run = '0;
        id_shift = '0;
        fail_run = '0;
        absent_left = '0;
        cfg_kind = owcc_pkg::KIND_TEMPERATURE;
        cfg_limit = 8'd3;
        cfg_hold = 16'd10;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: most negative reading, an all-ones read with no frame start
        // and a bad crc, a read restarted after three bytes, then the largest reading
        queue_frame({8'h00, 8'h80, 48'h0123_4567_89AB}, 1'b1, 1'b1);
        queue_frame(owcc_pkg::ALL_ONES_ID, 1'b0, 1'b0);
        queue_byte(8'h55, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_frame({8'hFF, 8'h7F, 48'hFEDC_BA98_7654}, 1'b1, 1'b1);
        queue_random(90);

        // no tolerance: every bad crc is a fault
        new_setting(owcc_pkg::KIND_TEMPERATURE, 8'd0, 16'd0, 55, 0);
        queue_random(100);

        // widest tolerance, ending on a run of failures
        new_setting(owcc_pkg::KIND_TEMPERATURE, 8'd255, 16'd0, 0, 55);
        queue_random(90);
        repeat (6)
            queue_frame({$urandom, $urandom}, 1'b0, 1'b1);

        // limit dropped under the count built up above
        new_setting(owcc_pkg::KIND_TEMPERATURE, 8'd1, 16'd0, 8, 8);
        repeat (2)
            queue_frame({$urandom, $urandom}, 1'b0, 1'b1);
        queue_random(85);

        // key frames, absence reported every time
        new_setting(KIND_KEY, 8'd1, 16'd0, 0, 0);
        queue_frame(owcc_pkg::ALL_ONES_ID, 1'b1, 1'b1);
        queue_frame(owcc_pkg::ALL_ONES_ID, 1'b0, 1'b1);
        queue_random(90);

        new_setting(KIND_KEY, 8'd255, 16'd2, 55, 0);
        queue_random(100);

        // absence held back for the longest count
        new_setting(KIND_KEY, 8'd0, 16'hFFFF, 0, 55);
        queue_random(85);

        new_setting(owcc_pkg::KIND_TEMPERATURE, 8'd3, 16'd10, 8, 8);
        queue_random(90);

        wait_idle();
        repeat (12) @(negedge clk);
        if (expected_q.size() != 0)
            flag_mismatch("results never delivered", expected_q.size(), 64'd0);
        $display("streamed %0d bytes in 8 register settings; %0d result words checked",
                 bytes_taken, results_checked);
        $display("  among them %0d crc failures, %0d fault readings, %0d absent-key reports",
                 crc_fail_results, fault_reports, absent_reports);
        if (mismatches == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/owcc_pkg.sv
rtl/core/owcc_regs.sv
rtl/core/owcc_front.sv
rtl/core/owcc_fifo.sv
rtl/core/owcc_back.sv
rtl/core/onewire_scratchpad_checker_unit.sv
rtl/core/owcc_checker.sv
tb/tb_onewire_scratchpad_checker_unit.sv
